### hdl/seven_segment_mux_frame_driver_defines.svh
// Assertion macros for the multiplexed seven-segment frame driver.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef SEVEN_SEGMENT_MUX_FRAME_DRIVER_DEFINES_SVH
`define SEVEN_SEGMENT_MUX_FRAME_DRIVER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define SSMFD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ssmfd: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted
`define SSMFD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ssmfd: next-cycle check failed");

`endif

### hdl/ssmfd_pkg.sv
// Shared types and constants of the seven-segment frame driver.
// No dependencies; used by the channel interfaces and the top level.
package ssmfd_pkg;

    // Parameter defaults
    localparam int DIGITS_DEF     = 4;
    localparam int TIMER_BITS_DEF = 16;

    // Field widths
    localparam int SEG_W    = 8;
    localparam int POS_W    = 3;
    localparam int STATUS_W = 3;
    localparam int FRAME_W  = 16;
    localparam int SHOWN_W  = 2;
    localparam int RET_W    = 16;
    localparam int DBIT_W   = 4;

    // Configuration port
    localparam int DATA_W    = 32;
    localparam int ADDR_W    = 5;
    localparam int REG_IDX_W = 3;

    // Register indexes
    localparam logic [REG_IDX_W-1:0] REG_SEG_FIRST = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_ACT_LOW   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_DIG0      = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_DIG1      = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_DIG2      = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_DIG3      = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_RETENTION = 3'd6;

    // Commands
    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_SHOW = 1'b1;

    typedef logic [STATUS_W-1:0] t_status;

    // Result status codes
    localparam t_status ST_SENT       = 3'd0;
    localparam t_status ST_RETAIN     = 3'd1;
    localparam t_status ST_BADPOS     = 3'd2;
    localparam t_status ST_UNASSIGNED = 3'd3;
    localparam t_status ST_BADCFG     = 3'd4;

    // Frame patterns
    localparam logic [FRAME_W-1:0] FRAME_BLANK  = 16'h0000;
    localparam logic [SEG_W-1:0]   BYTE_ALL_SET = 8'hFF;
    localparam logic [DBIT_W-1:0]  DBIT_NONE    = 4'hF;
    localparam int                 MAX_POS      = 4;

    // One queued result
    typedef struct packed {
        t_status            status;
        logic [FRAME_W-1:0] frame;
        logic               last;
    } t_result;

endpackage

### hdl/ssmfd_if.sv
// Valid/ready channel interfaces for tick and show requests and frame results.
// Depends on ssmfd_pkg for field widths.
interface ssmfd_req_if;
    logic                         valid;
    logic                         ready;
    logic                         command;
    logic [ssmfd_pkg::SEG_W-1:0]  segments;
    logic [ssmfd_pkg::POS_W-1:0]  position;

    modport source (output valid, command, segments, position, input ready);
    modport sink   (input valid, command, segments, position, output ready);
endinterface

interface ssmfd_res_if;
    logic                           valid;
    logic                           ready;
    ssmfd_pkg::t_status             status;
    logic [ssmfd_pkg::FRAME_W-1:0]  frame;
    logic                           last;

    modport source (output valid, status, frame, last, input ready);
    modport sink   (input valid, status, frame, last, output ready);
endinterface

### hdl/seven_segment_mux_frame_driver.sv
// Top level of the multiplexed seven-segment frame driver.
// Depends on ssmfd_pkg, the interfaces in ssmfd_if.sv and the assertion macro header.
//
//  channel  | dir | handshake     | payload
//  ---------+-----+---------------+-------------------------------------
//  i_req    | in  | valid/ready   | command, segments, position
//  o_res    | out | valid/ready   | status, frame, last
//  apb      | in  | psel/penable  | paddr, pwdata, prdata (pready tied)
//
// A transaction is registered on input, evaluated combinationally and its results land in a
// two-entry result queue. Ticks retire one per cycle. A show request needs two queue slots
// (blank then data frame), so a request that is sent waits until the queue has drained;
// rejected requests give one result and sustain one per cycle while the output takes results.
// Reset is synchronous; it clears the input stage, the queue, the registers and timer state.
// A stalled output holds the queue; a show request then waits in the input stage and i_req.ready drops.
`include "seven_segment_mux_frame_driver_defines.svh"

module seven_segment_mux_frame_driver #(
    parameter int DIGITS     = ssmfd_pkg::DIGITS_DEF,
    parameter int TIMER_BITS = ssmfd_pkg::TIMER_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    ssmfd_req_if.sink                      i_req,
    ssmfd_res_if.source                    o_res,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ssmfd_pkg::ADDR_W-1:0]   paddr,
    input  logic [ssmfd_pkg::DATA_W-1:0]   pwdata,
    output logic [ssmfd_pkg::DATA_W-1:0]   prdata,
    output logic                           pready
);

    localparam int CMP_W = (TIMER_BITS > ssmfd_pkg::RET_W) ? TIMER_BITS : ssmfd_pkg::RET_W;
    localparam int NUM_DBIT = 4;

    // Configuration registers
    logic                              r_seg_first;
    logic                              r_act_low;
    logic [2:0]                        r_dig0;
    logic [ssmfd_pkg::DBIT_W-1:0]      r_dig1, r_dig2, r_dig3;
    logic [ssmfd_pkg::RET_W-1:0]       r_retention;

    // Retention state
    logic                              r_first, n_first;
    logic [ssmfd_pkg::SHOWN_W-1:0]     r_shown, n_shown;
    logic [TIMER_BITS-1:0]             r_elapsed, n_elapsed;

    // Input register
    logic                              r_in_vld;
    logic                              r_in_cmd;
    logic [ssmfd_pkg::SEG_W-1:0]       r_in_seg;
    logic [ssmfd_pkg::POS_W-1:0]       r_in_pos;

    // Result queue, slot 0 is the head
    ssmfd_pkg::t_result                r_q [2];
    ssmfd_pkg::t_result                n_q [2];
    logic [1:0]                        r_q_cnt, n_q_cnt;

    logic                              w_cfg_wr;
    logic [ssmfd_pkg::REG_IDX_W-1:0]   w_cfg_idx;
    logic                              w_cfg_hit;
    logic                              w_pop;
    logic [1:0]                        w_cnt_after_pop;
    logic                              w_room;
    logic                              w_fire;
    logic                              w_show;

    logic [ssmfd_pkg::DBIT_W-1:0]      w_dbit [NUM_DBIT];
    logic [NUM_DBIT-1:0]               w_assigned;
    logic                              w_bad_cfg;
    logic                              w_bad_pos;
    logic                              w_ret_on;
    logic [ssmfd_pkg::POS_W-1:0]       w_next_pos;
    logic                              w_ret_block;
    logic [1:0]                        w_pos_idx;
    logic [ssmfd_pkg::DBIT_W-1:0]      w_sel_bit;
    logic [ssmfd_pkg::SEG_W-1:0]       w_pos_byte;
    logic [ssmfd_pkg::FRAME_W-1:0]     w_frame;
    ssmfd_pkg::t_status                w_res_status;
    logic                              w_two;

    // APB decode
    assign pready    = 1'b1;
    assign w_cfg_wr  = psel & penable & pwrite;
    assign w_cfg_idx = paddr[ssmfd_pkg::ADDR_W-1:2];

    always_comb begin
        w_cfg_hit = 1'b1;
        case (w_cfg_idx)
            ssmfd_pkg::REG_SEG_FIRST: prdata = ssmfd_pkg::DATA_W'(r_seg_first);
            ssmfd_pkg::REG_ACT_LOW:   prdata = ssmfd_pkg::DATA_W'(r_act_low);
            ssmfd_pkg::REG_DIG0:      prdata = ssmfd_pkg::DATA_W'(r_dig0);
            ssmfd_pkg::REG_DIG1:      prdata = {{28{r_dig1[3]}}, r_dig1};
            ssmfd_pkg::REG_DIG2:      prdata = {{28{r_dig2[3]}}, r_dig2};
            ssmfd_pkg::REG_DIG3:      prdata = {{28{r_dig3[3]}}, r_dig3};
            ssmfd_pkg::REG_RETENTION: prdata = ssmfd_pkg::DATA_W'(r_retention);
            default: begin
                prdata    = '0;
                w_cfg_hit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg_first <= 1'b0;
            r_act_low   <= 1'b0;
            r_dig0      <= '0;
            r_dig1      <= ssmfd_pkg::DBIT_NONE;
            r_dig2      <= ssmfd_pkg::DBIT_NONE;
            r_dig3      <= ssmfd_pkg::DBIT_NONE;
            r_retention <= '0;
        end else if (w_cfg_wr) begin
            case (w_cfg_idx)
                ssmfd_pkg::REG_SEG_FIRST: r_seg_first <= pwdata[0];
                ssmfd_pkg::REG_ACT_LOW:   r_act_low   <= pwdata[0];
                ssmfd_pkg::REG_DIG0:      r_dig0      <= pwdata[2:0];
                ssmfd_pkg::REG_DIG1:      r_dig1      <= pwdata[3:0];
                ssmfd_pkg::REG_DIG2:      r_dig2      <= pwdata[3:0];
                ssmfd_pkg::REG_DIG3:      r_dig3      <= pwdata[3:0];
                ssmfd_pkg::REG_RETENTION: r_retention <= pwdata[ssmfd_pkg::RET_W-1:0];
                default: ;
            endcase
        end
    end

    // Handshakes
    assign w_pop           = o_res.valid & o_res.ready;
    assign w_cnt_after_pop = r_q_cnt - 2'(w_pop);
    assign w_show          = r_in_cmd == ssmfd_pkg::CMD_SHOW;
    assign w_room          = w_two ? (w_cnt_after_pop == 2'd0) : (w_cnt_after_pop <= 2'd1);
    assign w_fire          = r_in_vld & (!w_show | w_room);
    assign i_req.ready     = !r_in_vld | w_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_req.ready) begin
            r_in_vld <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.ready & i_req.valid) begin
            r_in_cmd <= i_req.command;
            r_in_seg <= i_req.segments;
            r_in_pos <= i_req.position;
        end
    end

    // Digit bit table and configuration validity
    assign w_dbit[0] = {1'b0, r_dig0};
    assign w_dbit[1] = r_dig1;
    assign w_dbit[2] = r_dig2;
    assign w_dbit[3] = r_dig3;

    always_comb begin
        w_bad_cfg = 1'b0;
        for (int i = 0; i < NUM_DBIT; i++) begin
            w_assigned[i] = !w_dbit[i][3];
            if (w_dbit[i][3] && (w_dbit[i] != ssmfd_pkg::DBIT_NONE)) begin
                w_bad_cfg = 1'b1;
            end
        end
        for (int i = 0; i < NUM_DBIT; i++) begin
            for (int j = i + 1; j < NUM_DBIT; j++) begin
                if (w_assigned[i] && w_assigned[j] && (w_dbit[i] == w_dbit[j])) begin
                    w_bad_cfg = 1'b1;
                end
            end
        end
    end

    // Next assigned position after the shown one, wrapping to digit one
    always_comb begin
        w_next_pos = ssmfd_pkg::POS_W'(1);
        for (int i = NUM_DBIT - 1; i >= 1; i--) begin
            if ((i > int'(r_shown)) && (i < DIGITS) && w_assigned[i]) begin
                w_next_pos = ssmfd_pkg::POS_W'(i + 1);
            end
        end
    end

    // Request evaluation
    assign w_bad_pos   = (r_in_pos == '0) || (int'(r_in_pos) > DIGITS)
                         || (int'(r_in_pos) > ssmfd_pkg::MAX_POS);
    assign w_ret_on    = (r_retention != '0) && !r_first;
    assign w_ret_block = w_ret_on && ((r_in_pos != w_next_pos)
                         || (CMP_W'(r_elapsed) < CMP_W'(r_retention)));
    assign w_pos_idx   = 2'(r_in_pos - ssmfd_pkg::POS_W'(1));
    assign w_sel_bit   = w_dbit[w_pos_idx];
    assign w_pos_byte  = (ssmfd_pkg::SEG_W'(1) << w_sel_bit[2:0])
                         ^ (r_act_low ? ssmfd_pkg::BYTE_ALL_SET : '0);
    assign w_frame     = r_seg_first ? {r_in_seg, w_pos_byte} : {w_pos_byte, r_in_seg};

    always_comb begin
        if (w_bad_cfg) begin
            w_res_status = ssmfd_pkg::ST_BADCFG;
        end else if (w_bad_pos) begin
            w_res_status = ssmfd_pkg::ST_BADPOS;
        end else if (w_ret_block) begin
            w_res_status = ssmfd_pkg::ST_RETAIN;
        end else if (w_sel_bit[3]) begin
            w_res_status = ssmfd_pkg::ST_UNASSIGNED;
        end else begin
            w_res_status = ssmfd_pkg::ST_SENT;
        end
    end
    assign w_two = w_res_status == ssmfd_pkg::ST_SENT;

    // Retention state update
    always_comb begin
        n_first   = r_first;
        n_shown   = r_shown;
        n_elapsed = r_elapsed;
        if (w_cfg_wr && w_cfg_hit) begin
            n_first   = 1'b1;
            n_shown   = '0;
            n_elapsed = '0;
        end else if (w_fire && !w_show) begin
            if (r_elapsed != '1) begin
                n_elapsed = r_elapsed + TIMER_BITS'(1);
            end
        end else if (w_fire) begin
            if (!w_bad_cfg && !w_bad_pos && !w_ret_on) begin
                n_first = 1'b0;
            end
            if (w_two) begin
                n_shown   = w_pos_idx;
                n_elapsed = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first   <= 1'b1;
            r_shown   <= '0;
            r_elapsed <= '0;
        end else begin
            r_first   <= n_first;
            r_shown   <= n_shown;
            r_elapsed <= n_elapsed;
        end
    end

    // Result queue: pop shifts, then results append behind what remains
    always_comb begin
        n_q     = r_q;
        n_q_cnt = w_cnt_after_pop;
        if (w_pop) begin
            n_q[0] = r_q[1];
        end
        if (w_fire && w_show) begin
            if (w_two) begin
                n_q[0]  = '{status: ssmfd_pkg::ST_SENT, frame: ssmfd_pkg::FRAME_BLANK,
                            last: 1'b0};
                n_q[1]  = '{status: ssmfd_pkg::ST_SENT, frame: w_frame, last: 1'b1};
                n_q_cnt = 2'd2;
            end else begin
                n_q[w_cnt_after_pop[0]] = '{status: w_res_status,
                                            frame: ssmfd_pkg::FRAME_BLANK, last: 1'b1};
                n_q_cnt = w_cnt_after_pop + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_cnt <= '0;
        end else begin
            r_q_cnt <= n_q_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    assign o_res.valid  = r_q_cnt != '0;
    assign o_res.status = r_q[0].status;
    assign o_res.frame  = r_q[0].frame;
    assign o_res.last   = r_q[0].last;

    // Checks
    `SSMFD_ASSERT_IMP(a_q_cnt_range, i_clk, i_rst_n, 1'b1, r_q_cnt != 2'd3)
    `SSMFD_ASSERT_IMP(a_blank_has_partner, i_clk, i_rst_n, o_res.valid && !o_res.last, r_q_cnt == 2'd2)
    `SSMFD_ASSERT_NXT(a_data_follows_blank, i_clk, i_rst_n, w_pop && !o_res.last, o_res.valid && o_res.last && (o_res.status == ssmfd_pkg::ST_SENT))
    `SSMFD_ASSERT_NXT(a_sent_clears_timer, i_clk, i_rst_n, w_fire && w_show && w_two, r_elapsed == '0)
    `SSMFD_ASSERT_IMP(a_reject_blank, i_clk, i_rst_n, o_res.valid && (o_res.status != ssmfd_pkg::ST_SENT), (o_res.frame == ssmfd_pkg::FRAME_BLANK) && o_res.last)

endmodule

### sim/seven_segment_mux_frame_driver_tb.sv
// Self-checking testbench for the seven-segment frame driver: directed cases, random traffic
// under many register settings, output back-pressure and a long retention check.
// Depends on ssmfd_pkg, the channel interfaces in ssmfd_if.sv and the top level.
module seven_segment_mux_frame_driver_tb;

    localparam int CLK_HALF        = 4;
    localparam int RESET_CYCLES    = 11;
    localparam int SETTLE_CYCLES   = 10;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int REPORT_LIMIT    = 10;
    localparam int PHASES          = 10;
    localparam int PHASE_ITEMS     = 182;
    localparam int IDLE_PCT        = 24;

    localparam logic [ssmfd_pkg::REG_IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam logic [ssmfd_pkg::RET_W-1:0]     RET_MAX    = 16'hFFFF;

    // Predicts the result transactions of the driver and checks them in order
    class frame_tracker;
        bit                                seg_first;
        bit                                act_low;
        bit [2:0]                          dig0;
        bit signed [ssmfd_pkg::DBIT_W-1:0] dig_hi[1:3];
        bit [ssmfd_pkg::RET_W-1:0]         retention;
        bit                                first_req;
        bit [ssmfd_pkg::SHOWN_W-1:0]       shown;
        bit [15:0]                         elapsed;
        ssmfd_pkg::t_result                frames_due[$];
        int                                failures;
        int                                checked;
        int                                shows;
        int                                ticks;
        int                                writes;

        function new();
            seg_first = 1'b0;
            act_low   = 1'b0;
            dig0      = 3'd0;
            dig_hi[1] = ssmfd_pkg::DBIT_NONE;
            dig_hi[2] = ssmfd_pkg::DBIT_NONE;
            dig_hi[3] = ssmfd_pkg::DBIT_NONE;
            retention = '0;
            clear_retention();
        endfunction

        function void clear_retention();
            first_req = 1'b1;
            shown     = '0;
            elapsed   = '0;
        endfunction

        // Any known register write restarts the retention state
        function void set_reg(logic [ssmfd_pkg::REG_IDX_W-1:0] idx,
                              logic [ssmfd_pkg::DATA_W-1:0] val);
            case (idx)
                ssmfd_pkg::REG_SEG_FIRST: seg_first = val[0];
                ssmfd_pkg::REG_ACT_LOW:   act_low   = val[0];
                ssmfd_pkg::REG_DIG0:      dig0      = val[2:0];
                ssmfd_pkg::REG_DIG1:      dig_hi[1] = val[ssmfd_pkg::DBIT_W-1:0];
                ssmfd_pkg::REG_DIG2:      dig_hi[2] = val[ssmfd_pkg::DBIT_W-1:0];
                ssmfd_pkg::REG_DIG3:      dig_hi[3] = val[ssmfd_pkg::DBIT_W-1:0];
                ssmfd_pkg::REG_RETENTION: retention = val[ssmfd_pkg::RET_W-1:0];
                default:                  return;
            endcase
            writes++;
            clear_retention();
        endfunction

        // Bit of the position byte for a zero-based digit, -1 when none
        function int bit_of(int idx);
            if (idx == 0)
                return int'(dig0);
            if (idx <= 3)
                return int'(dig_hi[idx]);
            return -1;
        endfunction

        function bit layout_ok();
            for (int i = 0; i < ssmfd_pkg::MAX_POS; i++)
                if (bit_of(i) < -1)
                    return 1'b0;
            for (int i = 0; i < ssmfd_pkg::MAX_POS; i++)
                for (int j = i + 1; j < ssmfd_pkg::MAX_POS; j++)
                    if (bit_of(i) >= 0 && bit_of(i) == bit_of(j))
                        return 1'b0;
            return 1'b1;
        endfunction

        // Next assigned digit after the one shown, wrapping to digit one
        function logic [ssmfd_pkg::POS_W-1:0] upcoming_position();
            for (int i = shown + 1; i < ssmfd_pkg::MAX_POS; i++)
                if (bit_of(i) >= 0)
                    return ssmfd_pkg::POS_W'(i + 1);
            return ssmfd_pkg::POS_W'(1);
        endfunction

        function void refuse(ssmfd_pkg::t_status st);
            frames_due.push_back(ssmfd_pkg::t_result'{status: st,
                                 frame: ssmfd_pkg::FRAME_BLANK, last: 1'b1});
        endfunction

        function void note_request(logic cmd, logic [ssmfd_pkg::SEG_W-1:0] seg,
                                   logic [ssmfd_pkg::POS_W-1:0] pos);
            int                            b;
            logic [ssmfd_pkg::SEG_W-1:0]   digit_sel;
            logic [ssmfd_pkg::FRAME_W-1:0] fr;
            if (cmd == ssmfd_pkg::CMD_TICK) begin
                ticks++;
                if (elapsed != 16'hFFFF)
                    elapsed++;
                return;
            end
            shows++;
            if (!layout_ok()) begin
                refuse(ssmfd_pkg::ST_BADCFG);
                return;
            end
            if (pos < 1 || pos > ssmfd_pkg::MAX_POS) begin
                refuse(ssmfd_pkg::ST_BADPOS);
                return;
            end
            // Retention only bites once the first request has gone through
            if (retention != 0 && !first_req) begin
                if (pos != upcoming_position() || elapsed < retention) begin
                    refuse(ssmfd_pkg::ST_RETAIN);
                    return;
                end
            end else begin
                first_req = 1'b0;
            end
            b = bit_of(pos - 1);
            if (b < 0) begin
                refuse(ssmfd_pkg::ST_UNASSIGNED);
                return;
            end
            digit_sel = 8'd1 << b;
            if (act_low)
                digit_sel = digit_sel ^ ssmfd_pkg::BYTE_ALL_SET;
            fr = seg_first ? {seg, digit_sel} : {digit_sel, seg};
            frames_due.push_back(ssmfd_pkg::t_result'{status: ssmfd_pkg::ST_SENT,
                                 frame: ssmfd_pkg::FRAME_BLANK, last: 1'b0});
            frames_due.push_back(ssmfd_pkg::t_result'{status: ssmfd_pkg::ST_SENT,
                                 frame: fr, last: 1'b1});
            shown   = ssmfd_pkg::SHOWN_W'(pos - 1);
            elapsed = '0;
        endfunction

        function void note_failure(string what);
            failures++;
            if (failures <= REPORT_LIMIT)
                $display("mismatch: %s", what);
        endfunction

        function void check_frame(ssmfd_pkg::t_status st, logic [ssmfd_pkg::FRAME_W-1:0] fr,
                                  logic lst);
            ssmfd_pkg::t_result want;
            if (frames_due.size() == 0) begin
                note_failure($sformatf("unexpected result status %0d frame %h last %b",
                                       st, fr, lst));
                return;
            end
            want = frames_due.pop_front();
            checked++;
            if (st !== want.status || fr !== want.frame || lst !== want.last)
                note_failure($sformatf(
                    "expected status %0d frame %h last %b, got status %0d frame %h last %b",
                    want.status, want.frame, want.last, st, fr, lst));
        endfunction
    endclass

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [ssmfd_pkg::ADDR_W-1:0]  paddr;
    logic [ssmfd_pkg::DATA_W-1:0]  pwdata;
    logic [ssmfd_pkg::DATA_W-1:0]  prdata;
    logic                          pready;
    bit                            steady;
    bit                            hold_off_pending;
    frame_tracker                  tracker = new();

    ssmfd_req_if req_ch();
    ssmfd_res_if res_ch();

    seven_segment_mux_frame_driver dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_res   (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Offer one request transaction, idling first at random, and wait for it to be taken
    task automatic send_item(input logic cmd, input logic [ssmfd_pkg::SEG_W-1:0] seg,
                             input logic [ssmfd_pkg::POS_W-1:0] pos);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.command  <= cmd;
        req_ch.segments <= seg;
        req_ch.position <= pos;
        do @(posedge i_clk); while (req_ch.ready !== 1'b1);
        tracker.note_request(cmd, seg, pos);
    endtask

    // Drain: no results pending, then room for a tick still in flight
    task automatic settle();
        req_ch.valid <= 1'b0;
        while (tracker.frames_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [ssmfd_pkg::REG_IDX_W-1:0] idx,
                             input logic [ssmfd_pkg::DATA_W-1:0] val);
        settle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ssmfd_pkg::ADDR_W'({idx, 2'b00});
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        tracker.set_reg(idx, val);
    endtask

    // Random register setting: mostly distinct digit bits, now and then a broken layout
    task automatic random_setup(input bit with_retention);
        int                                 slots[8];
        int                                 k;
        int                                 j;
        int                                 tmp;
        int                                 r;
        logic [ssmfd_pkg::DBIT_W-1:0]       d;
        logic [ssmfd_pkg::REG_IDX_W-1:0]    hi_regs[1:3];
        hi_regs[1] = ssmfd_pkg::REG_DIG1;
        hi_regs[2] = ssmfd_pkg::REG_DIG2;
        hi_regs[3] = ssmfd_pkg::REG_DIG3;
        for (k = 0; k < 8; k++)
            slots[k] = k;
        for (k = 7; k > 0; k--) begin
            j        = $urandom_range(k);
            tmp      = slots[k];
            slots[k] = slots[j];
            slots[j] = tmp;
        end
        write_reg(ssmfd_pkg::REG_SEG_FIRST, $urandom_range(1));
        write_reg(ssmfd_pkg::REG_ACT_LOW, $urandom_range(1));
        write_reg(ssmfd_pkg::REG_DIG0, slots[0]);
        for (k = 1; k <= 3; k++) begin
            r = $urandom_range(99);
            if (r < 20)
                d = ssmfd_pkg::DBIT_NONE;
            else if (r < 22)
                d = ssmfd_pkg::DBIT_W'($urandom_range(8, 14));
            else if (r < 24)
                d = ssmfd_pkg::DBIT_W'(slots[0]);
            else
                d = ssmfd_pkg::DBIT_W'(slots[k]);
            write_reg(hi_regs[k], d);
        end
        write_reg(ssmfd_pkg::REG_RETENTION, with_retention ? $urandom_range(1, 6) : 0);
    endtask

    // Mostly well-timed requests for the next digit, the rest random requests and ticks
    task automatic random_phase(input int n);
        int done;
        int k;
        int r;
        done = 0;
        while (done < n) begin
            r = $urandom_range(99);
            if (r < 60) begin
                k = $urandom_range(0, tracker.retention == 0 ? 2 : tracker.retention + 1);
                repeat (k) send_item(ssmfd_pkg::CMD_TICK, ssmfd_pkg::SEG_W'($urandom),
                                     ssmfd_pkg::POS_W'($urandom));
                send_item(ssmfd_pkg::CMD_SHOW, ssmfd_pkg::SEG_W'($urandom),
                          tracker.upcoming_position());
                done += k + 1;
            end else if (r < 85) begin
                send_item(ssmfd_pkg::CMD_SHOW, ssmfd_pkg::SEG_W'($urandom),
                          ssmfd_pkg::POS_W'($urandom));
                done++;
            end else begin
                send_item(ssmfd_pkg::CMD_TICK, ssmfd_pkg::SEG_W'($urandom),
                          ssmfd_pkg::POS_W'($urandom));
                done++;
            end
        end
    endtask

    // Result side: check each transaction, stall at random, one long hold-off on request
    initial begin
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
                tracker.check_frame(res_ch.status, res_ch.frame, res_ch.last);
            if (hold_off_pending) begin
                hold_off_pending = 1'b0;
                res_ch.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
            end
            res_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Watchdog: too long without any transaction or register write
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
                (res_ch.valid === 1'b1 && res_ch.ready === 1'b1) ||
                (psel === 1'b1 && penable === 1'b1))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    // Stimulus
    initial begin
        req_ch.valid    <= 1'b0;
        req_ch.command  <= ssmfd_pkg::CMD_TICK;
        req_ch.segments <= '0;
        req_ch.position <= '0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        steady           = 1'b0;
        hold_off_pending = 1'b0;
        i_rst_n         <= 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: only digit one assigned, positions out of range
        send_item(ssmfd_pkg::CMD_SHOW, 8'hFF, 3'd1);
        send_item(ssmfd_pkg::CMD_SHOW, 8'h00, 3'd2);
        send_item(ssmfd_pkg::CMD_SHOW, 8'h55, 3'd0);
        send_item(ssmfd_pkg::CMD_SHOW, 8'hAA, 3'd5);
        send_item(ssmfd_pkg::CMD_SHOW, 8'h01, 3'd7);
        send_item(ssmfd_pkg::CMD_TICK, 8'hFF, 3'd7);

        // Segment byte on top, active-low switches, highest and lowest bits in use
        write_reg(ssmfd_pkg::REG_SEG_FIRST, 1);
        write_reg(ssmfd_pkg::REG_ACT_LOW, 1);
        write_reg(ssmfd_pkg::REG_DIG0, 7);
        write_reg(ssmfd_pkg::REG_DIG1, 0);
        write_reg(ssmfd_pkg::REG_DIG2, 3);
        write_reg(ssmfd_pkg::REG_DIG3, 5);
        send_item(ssmfd_pkg::CMD_SHOW, 8'h00, 3'd1);
        send_item(ssmfd_pkg::CMD_SHOW, 8'hFF, 3'd2);
        send_item(ssmfd_pkg::CMD_SHOW, 8'hA5, 3'd3);
        send_item(ssmfd_pkg::CMD_SHOW, 8'h5A, 3'd4);

        // Broken layouts: bit pattern below -1 at both ends, then a shared bit
        write_reg(ssmfd_pkg::REG_DIG1, 4'h8);
        send_item(ssmfd_pkg::CMD_SHOW, 8'h12, 3'd1);
        write_reg(ssmfd_pkg::REG_DIG1, 4'hE);
        send_item(ssmfd_pkg::CMD_SHOW, 8'h34, 3'd2);
        write_reg(ssmfd_pkg::REG_DIG1, 3);
        send_item(ssmfd_pkg::CMD_SHOW, 8'h56, 3'd3);

        // Retention: an unassigned first request still clears the first-request flag
        write_reg(ssmfd_pkg::REG_DIG1, 0);
        write_reg(ssmfd_pkg::REG_DIG3, ssmfd_pkg::DBIT_NONE);
        write_reg(ssmfd_pkg::REG_RETENTION, 3);
        send_item(ssmfd_pkg::CMD_SHOW, 8'h77, 3'd4);
        send_item(ssmfd_pkg::CMD_SHOW, 8'h78, 3'd2);
        repeat (3) send_item(ssmfd_pkg::CMD_TICK, ssmfd_pkg::SEG_W'($urandom),
                             ssmfd_pkg::POS_W'($urandom));
        send_item(ssmfd_pkg::CMD_SHOW, 8'h79, 3'd3);
        send_item(ssmfd_pkg::CMD_SHOW, 8'h7A, 3'd2);
        // A write beyond the register list must leave the retention state alone
        write_reg(REG_UNUSED, 32'hFFFF_FFFF);
        send_item(ssmfd_pkg::CMD_SHOW, 8'h7B, 3'd3);
        repeat (3) send_item(ssmfd_pkg::CMD_TICK, ssmfd_pkg::SEG_W'($urandom),
                             ssmfd_pkg::POS_W'($urandom));
        send_item(ssmfd_pkg::CMD_SHOW, 8'h7C, 3'd3);
        send_item(ssmfd_pkg::CMD_SHOW, 8'h7D, 3'd1);

        // Random phases, alternating retention off and on
        for (int phase = 0; phase < PHASES; phase++) begin
            random_setup(phase % 2 == 1);
            if (phase == 2)
                hold_off_pending = 1'b1;
            steady = (phase == 5);
            random_phase(PHASE_ITEMS);
            steady = 1'b0;
        end

        // Longest retention: the next digit stays refused after a few ticks
        write_reg(ssmfd_pkg::REG_SEG_FIRST, 0);
        write_reg(ssmfd_pkg::REG_ACT_LOW, 0);
        write_reg(ssmfd_pkg::REG_DIG0, 0);
        write_reg(ssmfd_pkg::REG_DIG1, 1);
        write_reg(ssmfd_pkg::REG_DIG2, 2);
        write_reg(ssmfd_pkg::REG_DIG3, 3);
        write_reg(ssmfd_pkg::REG_RETENTION, RET_MAX);
        send_item(ssmfd_pkg::CMD_SHOW, 8'h3C, 3'd1);
        repeat (3) send_item(ssmfd_pkg::CMD_TICK, ssmfd_pkg::SEG_W'($urandom),
                             ssmfd_pkg::POS_W'($urandom));
        send_item(ssmfd_pkg::CMD_SHOW, 8'h81, 3'd2);
        send_item(ssmfd_pkg::CMD_SHOW, 8'h18, 3'd1);

        settle();
        if (tracker.frames_due.size() != 0)
            tracker.note_failure($sformatf("%0d results never arrived",
                                           tracker.frames_due.size()));
        $display("Run covered %0d show requests and %0d ticks under %0d register writes,",
                 tracker.shows, tracker.ticks, tracker.writes);
        $display("with %0d result transactions checked and %0d mismatches.",
                 tracker.checked, tracker.failures);
        if (tracker.failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
